// ----- rtl/core/nrd_pkg.sv -----
// nrd_pkg: shared constants for the non-restoring divider
// no dependencies; used by every module of the divider by scoped name
`default_nettype none

package nrd_pkg;

    // fixed width of the operand and result ports
    localparam int unsigned FIELD_W   = 16;

    // default operand width of the division
    localparam int unsigned DEF_WIDTH = 16;

endpackage

`default_nettype wire

// ----- rtl/core/nrd_cell.sv -----
// nrd_cell: one non-restoring division step with its own item register
// uses nrd_pkg for the default width; chained WIDTH times by the top level
`default_nettype none

module nrd_cell #(
    parameter int unsigned WIDTH = nrd_pkg::DEF_WIDTH
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // from the previous cell
    input  wire logic                 i_valid,
    output logic                      o_ready,
    input  wire logic [WIDTH+1:0]     i_acc,
    input  wire logic [WIDTH-1:0]     i_q,
    input  wire logic [WIDTH-1:0]     i_m,
    // to the next cell
    output logic                      o_valid,
    input  wire logic                 i_ready,
    output logic [WIDTH+1:0]          o_acc,
    output logic [WIDTH-1:0]          o_q,
    output logic [WIDTH-1:0]          o_m
);

    localparam int unsigned ACC_W = WIDTH + 2;

    logic             r_valid;
    logic [ACC_W-1:0] r_acc;
    logic [WIDTH-1:0] r_q;
    logic [WIDTH-1:0] r_m;

    logic [ACC_W-1:0] n_acc;
    logic [WIDTH-1:0] n_q;
    logic [ACC_W-1:0] w_shift;
    logic [ACC_W-1:0] w_mext;

    // the cell moves on when empty or when its item leaves this cycle
    assign o_ready = !r_valid || i_ready;

    always_comb begin
        w_shift = {i_acc[ACC_W-2:0], i_q[WIDTH-1]};
        w_mext  = {2'b00, i_m};
        // sign of the old partial remainder picks subtract or add
        if (!i_acc[ACC_W-1]) begin
            n_acc = w_shift - w_mext;
        end else begin
            n_acc = w_shift + w_mext;
        end
        n_q = {i_q[WIDTH-2:0], !n_acc[ACC_W-1]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_acc <= n_acc;
            r_q   <= n_q;
            r_m   <= i_m;
        end
    end

    assign o_valid = r_valid;
    assign o_acc   = r_acc;
    assign o_q     = r_q;
    assign o_m     = r_m;

endmodule

`default_nettype wire

// ----- rtl/core/nrd_out.sv -----
// nrd_out: final remainder correction and the result register
// uses nrd_pkg for the port field width
`default_nettype none

module nrd_out #(
    parameter int unsigned WIDTH = nrd_pkg::DEF_WIDTH
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic [WIDTH+1:0]              i_acc,
    input  wire logic [WIDTH-1:0]              i_q,
    input  wire logic [WIDTH-1:0]              i_m,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic [nrd_pkg::FIELD_W-1:0]        o_quotient,
    output logic [nrd_pkg::FIELD_W-1:0]        o_remainder
);

    localparam int unsigned ACC_W = WIDTH + 2;
    localparam int unsigned FW    = nrd_pkg::FIELD_W;

    logic             r_valid;
    logic [FW-1:0]    r_quotient;
    logic [FW-1:0]    r_remainder;
    logic [ACC_W-1:0] w_rem;
    logic [FW-1:0]    n_quotient;
    logic [FW-1:0]    n_remainder;

    assign o_ready = !r_valid || i_ready;

    // a negative remainder gets the divisor added back once
    always_comb begin
        if (i_acc[ACC_W-1]) begin
            w_rem = i_acc + {2'b00, i_m};
        end else begin
            w_rem = i_acc;
        end
    end

    generate
        if (WIDTH >= FW) begin : g_trunc
            assign n_quotient  = i_q[FW-1:0];
            assign n_remainder = w_rem[FW-1:0];
        end else begin : g_ext
            assign n_quotient  = {{(FW-WIDTH){1'b0}}, i_q};
            assign n_remainder = {{(FW-WIDTH){1'b0}}, w_rem[WIDTH-1:0]};
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_quotient  <= n_quotient;
            r_remainder <= n_remainder;
        end
    end

    assign o_valid     = r_valid;
    assign o_quotient  = r_quotient;
    assign o_remainder = r_remainder;

endmodule

`default_nettype wire

// ----- rtl/core/non_restoring_divider_top.sv -----
// non_restoring_divider_top: unsigned divider built as a chain of WIDTH step cells
// depends on nrd_pkg, nrd_cell and nrd_out
//
//   port group   direction   handshake            payload
//   operands     in          i_valid / o_ready    i_dividend, i_divisor
//   results      out         o_valid / i_ready    o_quotient, o_remainder
//
// one item enters per cycle while no stall holds the chain; each item passes WIDTH cells
// and then the result register before its result shows at the output
// every cell holds its item until the next one is free, so bubbles close up
// and items are taken while a result waits at the output
// reset (synchronous, active low) clears only the valid bits of the chain
`default_nettype none

module non_restoring_divider_top #(
    parameter int unsigned WIDTH = nrd_pkg::DEF_WIDTH
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic [nrd_pkg::FIELD_W-1:0]   i_dividend,
    input  wire logic [nrd_pkg::FIELD_W-1:0]   i_divisor,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic [nrd_pkg::FIELD_W-1:0]        o_quotient,
    output logic [nrd_pkg::FIELD_W-1:0]        o_remainder
);

    localparam int unsigned ACC_W = WIDTH + 2;
    localparam int unsigned FW    = nrd_pkg::FIELD_W;

    logic             w_valid [0:WIDTH];
    logic             w_ready [0:WIDTH];
    logic [ACC_W-1:0] w_acc   [0:WIDTH];
    logic [WIDTH-1:0] w_q     [0:WIDTH];
    logic [WIDTH-1:0] w_m     [0:WIDTH];

    // operands take the low WIDTH bits of the ports, zero-extended when WIDTH exceeds the port width
    generate
        if (WIDTH <= FW) begin : g_in_trunc
            assign w_q[0] = i_dividend[WIDTH-1:0];
            assign w_m[0] = i_divisor[WIDTH-1:0];
        end else begin : g_in_ext
            assign w_q[0] = {{(WIDTH-FW){1'b0}}, i_dividend};
            assign w_m[0] = {{(WIDTH-FW){1'b0}}, i_divisor};
        end
    endgenerate

    assign w_valid[0] = i_valid;
    assign w_acc[0]   = '0;
    assign o_ready    = w_ready[0];

    generate
        for (genvar k = 0; k < WIDTH; k++) begin : g_cell
            nrd_cell #(
                .WIDTH (WIDTH)
            ) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_valid (w_valid[k]),
                .o_ready (w_ready[k]),
                .i_acc   (w_acc[k]),
                .i_q     (w_q[k]),
                .i_m     (w_m[k]),
                .o_valid (w_valid[k+1]),
                .i_ready (w_ready[k+1]),
                .o_acc   (w_acc[k+1]),
                .o_q     (w_q[k+1]),
                .o_m     (w_m[k+1])
            );
        end
    endgenerate

    nrd_out #(
        .WIDTH (WIDTH)
    ) u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_valid[WIDTH]),
        .o_ready     (w_ready[WIDTH]),
        .i_acc       (w_acc[WIDTH]),
        .i_q         (w_q[WIDTH]),
        .i_m         (w_m[WIDTH]),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_quotient  (o_quotient),
        .o_remainder (o_remainder)
    );

endmodule

`default_nettype wire

// ----- rtl/core/nrd_checker.sv -----
// nrd_props: port-level checks on the divider top level
// depends on nrd_pkg; attached to non_restoring_divider_top by the bind below
`default_nettype none

module nrd_props (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          o_ready,
    input  wire logic                          o_valid,
    input  wire logic                          i_ready,
    input  wire logic [nrd_pkg::FIELD_W-1:0]   o_quotient,
    input  wire logic [nrd_pkg::FIELD_W-1:0]   o_remainder
);

    // a result held back keeps its valid
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid)
        else $error("result dropped while stalled");

    // a result held back keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> $stable(o_quotient) && $stable(o_remainder))
        else $error("result payload changed while stalled");

    // with the result register empty the whole chain can move
    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("input blocked with empty output");

    // reset empties the chain, so no result and full readiness follow
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && o_ready)
        else $error("chain not empty after reset");

endmodule

bind non_restoring_divider_top nrd_props u_nrd_props (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_ready     (o_ready),
    .o_valid     (o_valid),
    .i_ready     (i_ready),
    .o_quotient  (o_quotient),
    .o_remainder (o_remainder)
);

`default_nettype wire

// ----- tb/sv/nrd_checker.sv -----
// nrd_checker: watches both channels of the divider, predicts quotient and remainder
// depends on nrd_pkg; instantiated by tb beside the divider and reports mismatches to it
module nrd_checker #(
    parameter int unsigned WIDTH = nrd_pkg::DEF_WIDTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_in_ready,
    input  logic [nrd_pkg::FIELD_W-1:0]   i_dividend,
    input  logic [nrd_pkg::FIELD_W-1:0]   i_divisor,
    input  logic                          i_out_valid,
    input  logic                          i_out_ready,
    input  logic [nrd_pkg::FIELD_W-1:0]   i_quotient,
    input  logic [nrd_pkg::FIELD_W-1:0]   i_remainder,
    output int                            o_mismatches,
    output int                            o_outstanding,
    output int                            o_results
);

    typedef struct packed {
        logic [nrd_pkg::FIELD_W-1:0] quotient;
        logic [nrd_pkg::FIELD_W-1:0] remainder;
    } t_quot_rem;

    t_quot_rem expected_results[$];
    int        mismatches  = 0;
    int        outstanding = 0;
    int        results     = 0;

    assign o_mismatches  = mismatches;
    assign o_outstanding = outstanding;
    assign o_results     = results;

    // partial remainder kept two bits wider than the operands, sign in the top bit
    function automatic t_quot_rem divide_nonrestoring(
        input logic [nrd_pkg::FIELD_W-1:0] dvd,
        input logic [nrd_pkg::FIELD_W-1:0] dvs
    );
        logic [WIDTH+1:0] acc;
        logic [WIDTH+1:0] dsr;
        logic [WIDTH-1:0] quo;
        t_quot_rem        res;
        acc = '0;
        quo = dvd[WIDTH-1:0];
        dsr = {2'b00, dvs[WIDTH-1:0]};
        for (int i = 0; i < WIDTH; i++) begin
            acc = {acc[WIDTH:0], quo[WIDTH-1]};
            quo = {quo[WIDTH-2:0], 1'b0};
            if (acc[WIDTH+1]) begin
                acc = acc + dsr;
            end else begin
                acc = acc - dsr;
            end
            if (!acc[WIDTH+1]) begin
                quo[0] = 1'b1;
            end
        end
        // one correction of a negative final remainder
        if (acc[WIDTH+1]) begin
            acc = acc + dsr;
        end
        res.quotient  = nrd_pkg::FIELD_W'(quo);
        res.remainder = nrd_pkg::FIELD_W'(acc[WIDTH-1:0]);
        return res;
    endfunction

    always @(posedge i_clk) begin : watch
        t_quot_rem exp_res;
        if (i_rst_n) begin
            if (i_out_valid && i_out_ready) begin
                results++;
                if (expected_results.size() == 0) begin
                    if (mismatches < 10) begin
                        $display("unexpected result: quotient %h remainder %h",
                                 i_quotient, i_remainder);
                    end
                    mismatches++;
                end else begin
                    exp_res = expected_results.pop_front();
                    if (exp_res.quotient !== i_quotient ||
                        exp_res.remainder !== i_remainder) begin
                        if (mismatches < 10) begin
                            $display("mismatch: quotient exp %h got %h, remainder exp %h got %h",
                                     exp_res.quotient, i_quotient,
                                     exp_res.remainder, i_remainder);
                        end
                        mismatches++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                expected_results.push_back(divide_nonrestoring(i_dividend, i_divisor));
            end
            outstanding = expected_results.size();
        end
    end

endmodule

// ----- tb/sv/tb.sv -----
// tb: drives operand pairs into the divider under three idle patterns and gives the verdict
// depends on nrd_pkg, non_restoring_divider_top and nrd_checker
module tb;

    localparam int unsigned WIDTH = nrd_pkg::DEF_WIDTH;
    localparam int          RANDOM_PER_PHASE = 183;
    localparam int          N_DIRECTED = 21;

    logic                          i_clk       = 1'b0;
    logic                          i_rst_n     = 1'b0;
    logic                          i_valid     = 1'b0;
    logic                          i_ready     = 1'b0;
    logic [nrd_pkg::FIELD_W-1:0]   i_dividend  = '0;
    logic [nrd_pkg::FIELD_W-1:0]   i_divisor   = '0;
    logic                          o_ready;
    logic                          o_valid;
    logic [nrd_pkg::FIELD_W-1:0]   o_quotient;
    logic [nrd_pkg::FIELD_W-1:0]   o_remainder;

    int mismatches;
    int outstanding;
    int results;
    int send_idle  = 24;
    int recv_idle  = 83;
    int items_sent = 0;

    // {dividend, divisor}: zero divisors, extremes, equal and near-equal operands
    logic [31:0] directed_pairs [N_DIRECTED] = '{
        32'h0000_0000, 32'h0000_0001, 32'hFFFF_0000, 32'h1234_0000, 32'hFFFF_0001,
        32'hFFFF_FFFF, 32'h0000_FFFF, 32'h0001_FFFF, 32'hFFFE_FFFF, 32'hFFFF_FFFE,
        32'h8000_8000, 32'h7FFF_8000, 32'h8000_7FFF, 32'hFFFF_0002, 32'h0005_0003,
        32'h0064_000A, 32'hAAAA_5555, 32'h5555_AAAA, 32'h0001_0001, 32'hFFFF_8001,
        32'h7FFF_0007
    };

    int send_idle_by_phase [3] = '{24, 83, 0};
    int recv_idle_by_phase [3] = '{83, 24, 0};

    non_restoring_divider_top #(
        .WIDTH(WIDTH)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_dividend  (i_dividend),
        .i_divisor   (i_divisor),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_quotient  (o_quotient),
        .o_remainder (o_remainder)
    );

    nrd_checker #(
        .WIDTH(WIDTH)
    ) u_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_valid),
        .i_in_ready    (o_ready),
        .i_dividend    (i_dividend),
        .i_divisor     (i_divisor),
        .i_out_valid   (o_valid),
        .i_out_ready   (i_ready),
        .i_quotient    (o_quotient),
        .i_remainder   (o_remainder),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding),
        .o_results     (results)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #1600000;
        $display("timeout with %0d results outstanding", outstanding);
        $display("TB_ERROR");
        $finish;
    end

    always @(negedge i_clk) begin
        i_ready <= ($urandom_range(99) >= recv_idle);
    end

    // presents one item and returns at the falling edge after it was taken
    task automatic push_operands(input logic [15:0] dvd, input logic [15:0] dvs);
        while ($urandom_range(99) < send_idle) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid    <= 1'b1;
        i_dividend <= dvd;
        i_divisor  <= dvs;
        do @(posedge i_clk); while (!o_ready);
        items_sent++;
        @(negedge i_clk);
    endtask

    initial begin : stimulus
        logic [15:0] dvd;
        logic [15:0] dvs;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        for (int p = 0; p < 3; p++) begin
            send_idle = send_idle_by_phase[p];
            recv_idle = recv_idle_by_phase[p];
            if (p == 0) begin
                foreach (directed_pairs[k]) begin
                    push_operands(directed_pairs[k][31:16], directed_pairs[k][15:0]);
                end
            end
            repeat (RANDOM_PER_PHASE) begin
                dvd = 16'($urandom());
                dvs = 16'($urandom());
                case ($urandom_range(9))
                    0: dvs = '0;
                    1: dvs = 16'($urandom_range(1, 15));
                    2: dvs = dvd ^ 16'($urandom_range(0, 3));
                    3: dvd = 16'($urandom_range(0, 255));
                    4: dvs = 16'($urandom_range(16'h8000, 16'hFFFF));
                    default: ;
                endcase
                push_operands(dvd, dvs);
            end
        end
        i_valid <= 1'b0;
        while (outstanding != 0) @(posedge i_clk);
        repeat (WIDTH + 8) @(posedge i_clk);
        $display("%0d operand pairs divided (%0d directed, rest random) over three idle patterns",
                 items_sent, N_DIRECTED);
        $display("%0d results compared, %0d mismatches", results, mismatches);
        if (mismatches == 0 && outstanding == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/core/nrd_pkg.sv
rtl/core/nrd_cell.sv
rtl/core/nrd_out.sv
rtl/core/non_restoring_divider_top.sv
rtl/core/nrd_checker.sv
tb/sv/nrd_checker.sv
tb/sv/tb.sv
